// ----- hdl/rjms_pkg.sv -----
`default_nettype none

package rjms_pkg;

    localparam int NUM_CH = 3;
    localparam int CH_W = 2;
    localparam int OUT_W = 8;
    localparam int STEP_W = 3;

    localparam logic [CH_W-1:0] CH_FIRST = 2'd0;
    localparam logic [CH_W-1:0] CH_LAST = 2'd2;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd7;
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd0;

    typedef struct packed {
        logic capture;
        logic observe;
        logic span;
        logic load;
        logic step;
        logic last;
        logic publish;
        logic [CH_W-1:0] ch;
        logic [STEP_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic action;
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/rjms_ctrl.sv -----
`default_nettype none

module rjms_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  rjms_pkg::status_t status,
    output rjms_pkg::cmd_t    cmd
);

    import rjms_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_LOAD,
        ST_STEP,
        ST_PUB
    } state_t;

    state_t state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ch_next = ch_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        cmd.ch = ch_reg;
        cmd.cnt = cnt_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.action)
                    begin
                        cmd.capture = 1'b1;
                        state_next = ST_SPAN;
                    end
                    else
                    begin
                        cmd.observe = 1'b1;
                    end
                end
            end
            ST_SPAN:
            begin
                cmd.span = 1'b1;
                ch_next = CH_FIRST;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                cnt_next = STEP_FIRST;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                cmd.last = (cnt_reg == STEP_LAST);
                if (cnt_reg == STEP_LAST)
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = ST_PUB;
                    end
                    else
                    begin
                        ch_next = ch_reg + CH_W'(1);
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - STEP_W'(1);
                end
            end
            ST_PUB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.publish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg <= CH_FIRST;
            cnt_reg <= STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg <= ch_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_norm_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.action) |=> (state_reg == ST_SPAN))
        else $error("normalize word did not start the range pass");

    a_last_step_publishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && cnt_reg == STEP_LAST && ch_reg == CH_LAST)
        |=> (state_reg == ST_PUB))
        else $error("divider finished without publishing");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_reg <= CH_LAST))
        else $error("channel index out of range");

    a_valid_from_pub: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUB))
        else $error("output word raised outside publish");

endmodule

`default_nettype wire

// ----- hdl/rjms_datapath.sv -----
`default_nettype none

module rjms_datapath
#(
    parameter int SAMPLE_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rjms_pkg::cmd_t               cmd,
    output rjms_pkg::status_t            status,
    input  logic                         action,
    input  logic                         first_of_frame,
    input  logic [SAMPLE_BITS-1:0]       red_in,
    input  logic [SAMPLE_BITS-1:0]       green_in,
    input  logic [SAMPLE_BITS-1:0]       blue_in,
    output logic [rjms_pkg::OUT_W-1:0]   red_out,
    output logic [rjms_pkg::OUT_W-1:0]   green_out,
    output logic [rjms_pkg::OUT_W-1:0]   blue_out
);

    import rjms_pkg::*;

    localparam int NUM_W = SAMPLE_BITS + 9;
    localparam int DEN_W = SAMPLE_BITS + 1;

    logic [SAMPLE_BITS-1:0] sample_in [NUM_CH];
    logic [SAMPLE_BITS-1:0] lo_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] lo_next [NUM_CH];
    logic [SAMPLE_BITS-1:0] hi_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] hi_next [NUM_CH];
    logic [SAMPLE_BITS-1:0] span_w [NUM_CH];
    logic [SAMPLE_BITS-1:0] smp_reg [NUM_CH];
    logic [OUT_W-1:0] res_reg [NUM_CH];
    logic [OUT_W-1:0] out_reg [NUM_CH];
    logic [SAMPLE_BITS-1:0] d_reg;
    logic [SAMPLE_BITS-1:0] d_next;
    logic [SAMPLE_BITS-1:0] diff_w;
    logic [NUM_W-1:0] num_w;
    logic [DEN_W-1:0] den_w;
    logic [NUM_W-1:0] den_top_w;
    logic [NUM_W-1:0] den_sh_w;
    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] rem_next;
    logic [OUT_W-1:0] q_reg;
    logic [OUT_W-1:0] q_next;
    logic [OUT_W-1:0] res_w;
    logic ge_w;
    logic zero_reg;
    logic sat_reg;

    assign sample_in[0] = red_in;
    assign sample_in[1] = green_in;
    assign sample_in[2] = blue_in;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            lo_next[c] = lo_reg[c];
            hi_next[c] = hi_reg[c];
            if (cmd.observe)
            begin
                if (first_of_frame)
                begin
                    lo_next[c] = sample_in[c];
                    hi_next[c] = sample_in[c];
                end
                else
                begin
                    if (sample_in[c] < lo_reg[c])
                    begin
                        lo_next[c] = sample_in[c];
                    end
                    if (sample_in[c] > hi_reg[c])
                    begin
                        hi_next[c] = sample_in[c];
                    end
                end
            end
            span_w[c] = (hi_reg[c] >= lo_reg[c]) ? (hi_reg[c] - lo_reg[c]) : '0;
        end
        d_next = span_w[0];
        if (span_w[1] > d_next)
        begin
            d_next = span_w[1];
        end
        if (span_w[2] > d_next)
        begin
            d_next = span_w[2];
        end
    end

    always_comb
    begin
        diff_w = smp_reg[cmd.ch] - lo_reg[cmd.ch];
        num_w = (NUM_W'(diff_w) << 9) - (NUM_W'(diff_w) << 1) + NUM_W'(d_reg);
        den_w = {d_reg, 1'b0};
        den_top_w = NUM_W'(den_w) << 8;
        den_sh_w = NUM_W'(den_w) << cmd.cnt;
        ge_w = (rem_reg >= den_sh_w);
        rem_next = ge_w ? (rem_reg - den_sh_w) : rem_reg;
        q_next = q_reg;
        q_next[cmd.cnt] = ge_w;
        if (zero_reg)
        begin
            res_w = '0;
        end
        else if (sat_reg)
        begin
            res_w = '1;
        end
        else
        begin
            res_w = q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                lo_reg[c] <= '1;
                hi_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                lo_reg[c] <= lo_next[c];
                hi_reg[c] <= hi_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                smp_reg[c] <= sample_in[c];
            end
        end
        if (cmd.span)
        begin
            d_reg <= d_next;
        end
        if (cmd.load)
        begin
            rem_reg <= num_w;
            q_reg <= '0;
            zero_reg <= (d_reg == '0) || (smp_reg[cmd.ch] < lo_reg[cmd.ch]);
            sat_reg <= (num_w >= den_top_w);
        end
        if (cmd.step)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            if (cmd.last)
            begin
                res_reg[cmd.ch] <= res_w;
            end
        end
        if (cmd.publish)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_reg[c] <= res_reg[c];
            end
        end
    end

    assign status.action = action;
    assign red_out = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out = out_reg[2];

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !zero_reg && !sat_reg)
        |-> (rem_reg < (NUM_W'(den_w) << ({1'b0, cmd.cnt} + 4'd1))))
        else $error("divider remainder out of bound");

    a_span_max: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.span |=> ((d_reg >= $past(span_w[0])) && (d_reg >= $past(span_w[1]))
                      && (d_reg >= $past(span_w[2]))))
        else $error("range is not the widest channel range");

endmodule

`default_nettype wire

// ----- hdl/rgb_joint_minmax_stretch_unit.sv -----
`default_nettype none

// Joint min/max contrast stretch for RGB pixels. Stream each frame twice: observe words
// (action 0) track the minimum and maximum of every channel, first_of_frame restarting
// them; normalize words (action 1) return round((v - min) * 255 / D) per channel, D being
// the widest channel range, clamped to 0 below the minimum and saturated at 255, all zero
// when D is 0. An observe word never stalls the input. A normalize word stalls further
// input while the unit captures it and finds D, then per channel runs one load and eight
// steps of a single shared restoring divider that yields one quotient bit per cycle, and
// publishes into the output register, which may stall while the next word is accepted.

module rgb_joint_minmax_stretch_unit
#(
    parameter int SAMPLE_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic                         first_of_frame,
    input  logic [SAMPLE_BITS-1:0]       red_in,
    input  logic [SAMPLE_BITS-1:0]       green_in,
    input  logic [SAMPLE_BITS-1:0]       blue_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rjms_pkg::OUT_W-1:0]   red_out,
    output logic [rjms_pkg::OUT_W-1:0]   green_out,
    output logic [rjms_pkg::OUT_W-1:0]   blue_out
);

    import rjms_pkg::*;

    cmd_t cmd;
    status_t status;

    rjms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rjms_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (action),
        .first_of_frame (first_of_frame),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out)
    );

endmodule

`default_nettype wire
